// ----- sv/gmcp_pkg.sv -----
// Shared constants, register indexes and control types for the grid minimum cost path block.
`timescale 1ns / 1ps
package gmcp_pkg;

    localparam int DEF_MAX_COLS  = 256;
    localparam int DEF_MAX_ROWS  = 256;
    localparam int DEF_COST_BITS = 16;

    localparam int ACC_W     = 32;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

    typedef struct packed {
        logic vld;
        logic last_row;
        logic last_col;
        logic fin;
    } gmcp_ctl_t;

endpackage

// ----- sv/gmcp_path.sv -----
// Row buffer memory, neighbor registers and per-cell cost update stage.
`timescale 1ns / 1ps
module gmcp_path
    import gmcp_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int COL_AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  gmcp_ctl_t               issue,
    input  logic [COL_AW-1:0]       issue_col,
    input  logic signed [ACC_W-1:0] issue_cost,
    output gmcp_ctl_t               done,
    output logic signed [ACC_W-1:0] path_cost
);

    logic signed [ACC_W-1:0] row_mem [MAX_COLS];
    logic signed [ACC_W-1:0] rd_data_reg;

    gmcp_ctl_t               s1_ctl_reg;
    logic [COL_AW-1:0]       s1_col_reg;
    logic signed [ACC_W-1:0] s1_cost_reg;

    logic                    fwd_vld_reg;
    logic [COL_AW-1:0]       fwd_col_reg;
    logic signed [ACC_W-1:0] fwd_data_reg;

    logic signed [ACC_W-1:0] right_cost_reg;
    logic signed [ACC_W-1:0] diag_cost_reg;

    logic signed [ACC_W-1:0] down;
    logic signed [ACC_W-1:0] min_rd;
    logic signed [ACC_W-1:0] min_all;
    logic signed [ACC_W-1:0] val;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= row_mem[issue_col];
        if (s1_ctl_reg.vld)
        begin
            row_mem[s1_col_reg] <= val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg     <= '0;
            fwd_vld_reg    <= 1'b0;
            right_cost_reg <= '0;
            diag_cost_reg  <= '0;
        end
        else
        begin
            s1_ctl_reg  <= issue;
            fwd_vld_reg <= s1_ctl_reg.vld;
            if (s1_ctl_reg.vld)
            begin
                right_cost_reg <= val;
                diag_cost_reg  <= down;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_col_reg   <= issue_col;
        s1_cost_reg  <= issue_cost;
        fwd_col_reg  <= s1_col_reg;
        fwd_data_reg <= val;
    end

    // take the write of the previous cell when it hit the same column
    always_comb
    begin
        down    = (fwd_vld_reg && (fwd_col_reg == s1_col_reg)) ? fwd_data_reg : rd_data_reg;
        min_rd  = (right_cost_reg < down) ? right_cost_reg : down;
        min_all = (diag_cost_reg < min_rd) ? diag_cost_reg : min_rd;
        if (s1_ctl_reg.last_row && s1_ctl_reg.last_col)
        begin
            val = s1_cost_reg;
        end
        else if (s1_ctl_reg.last_row)
        begin
            val = s1_cost_reg + right_cost_reg;
        end
        else if (s1_ctl_reg.last_col)
        begin
            val = s1_cost_reg + down;
        end
        else
        begin
            val = s1_cost_reg + min_all;
        end
    end

    assign done      = s1_ctl_reg;
    assign path_cost = val;

endmodule

// ----- sv/grid_min_cost_path_dp.sv -----
// Top level of the grid minimum cost path block: configuration, cell sequencing and result register.
//
//   channel   direction  handshake          payload
//   cfg       in         cfg_wr_en          cfg_index, cfg_data
//   in        in         in_valid/in_stall  cell_cost
//   out       out        out_valid/out_stall min_cost
//
// One cell per cycle while in_stall is low; each cell reads its column of the row buffer in the
// accept cycle and updates it in the following cycle. A result passes the s1 stage registers and
// then enters the output or the one spare register, where results queue; the final cell of a grid
// is held only while both would still be full after this cycle's transfer, so even grids of a
// single cell run one per cycle while out_stall stays low. Reset restores a 1 by 1 grid; the row
// buffer is not cleared, since a grid always writes a column before it uses the value read from it.
`timescale 1ns / 1ps
module grid_min_cost_path_dp
    import gmcp_pkg::*;
#(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int COST_BITS = DEF_COST_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [COST_BITS-1:0] cell_cost,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [ACC_W-1:0]     min_cost
);

    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [ROW_AW-1:0] row_last_reg;
    logic [COL_AW-1:0] col_last_reg;
    logic [ROW_AW-1:0] row_pos_reg;
    logic [COL_AW-1:0] col_pos_reg;
    logic [ROW_AW-1:0] row_last_next;
    logic [COL_AW-1:0] col_last_next;

    logic                    out_valid_reg;
    logic signed [ACC_W-1:0] min_cost_reg;
    logic                    spare_valid_reg;
    logic signed [ACC_W-1:0] spare_cost_reg;

    logic                    res_push;
    logic                    res_pop;
    logic [1:0]              res_count;

    logic                    final_next;
    logic                    accept;
    gmcp_ctl_t               issue;
    gmcp_ctl_t               done;
    logic signed [ACC_W-1:0] path_cost;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            row_last_next = '0;
            col_last_next = '0;
        end
        else
        begin
            row_last_next = (32'(cfg_data) > 32'(MAX_ROWS)) ? ROW_AW'(MAX_ROWS - 1)
                                                             : ROW_AW'(32'(cfg_data) - 32'd1);
            col_last_next = (32'(cfg_data) > 32'(MAX_COLS)) ? COL_AW'(MAX_COLS - 1)
                                                             : COL_AW'(32'(cfg_data) - 32'd1);
        end
    end

    assign res_push   = done.vld && done.fin;
    assign res_pop    = out_valid_reg && !out_stall;
    assign res_count  = 2'(out_valid_reg) + 2'(spare_valid_reg) + 2'(res_push) - 2'(res_pop);
    assign final_next = (row_pos_reg == '0) && (col_pos_reg == '0);
    assign in_stall   = final_next && (res_count >= 2'd2);
    assign accept     = in_valid && !in_stall;

    always_comb
    begin
        issue.vld      = accept;
        issue.last_row = (row_pos_reg == row_last_reg);
        issue.last_col = (col_pos_reg == col_last_reg);
        issue.fin      = final_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_last_reg <= '0;
            col_last_reg <= '0;
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ROW_COUNT:
                begin
                    row_last_reg <= row_last_next;
                    row_pos_reg  <= row_last_next;
                    col_pos_reg  <= col_last_reg;
                end
                REG_COL_COUNT:
                begin
                    col_last_reg <= col_last_next;
                    col_pos_reg  <= col_last_next;
                    row_pos_reg  <= row_last_reg;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            if (col_pos_reg == '0)
            begin
                col_pos_reg <= col_last_reg;
                row_pos_reg <= (row_pos_reg == '0) ? row_last_reg : row_pos_reg - ROW_AW'(1);
            end
            else
            begin
                col_pos_reg <= col_pos_reg - COL_AW'(1);
            end
        end
    end

    gmcp_path #(
        .MAX_COLS (MAX_COLS)
    ) u_path (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .issue_col  (col_pos_reg),
        .issue_cost (ACC_W'(cell_cost)),
        .done       (done),
        .path_cost  (path_cost)
    );

    // hold the result until its transfer; park a second one in the spare register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (spare_valid_reg)
            begin
                out_valid_reg   <= 1'b1;
                spare_valid_reg <= res_push;
            end
            else
            begin
                out_valid_reg <= res_push;
            end
        end
        else if (res_push)
        begin
            spare_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (spare_valid_reg)
            begin
                min_cost_reg <= spare_cost_reg;
                if (res_push)
                begin
                    spare_cost_reg <= path_cost;
                end
            end
            else if (res_push)
            begin
                min_cost_reg <= path_cost;
            end
        end
        else if (res_push)
        begin
            spare_cost_reg <= path_cost;
        end
    end

    assign out_valid = out_valid_reg;
    assign min_cost  = min_cost_reg;

    a_spare_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && spare_valid_reg) |-> res_pop)
        else $error("result arrived while both result registers occupied");

    a_spare_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        spare_valid_reg |-> out_valid_reg)
        else $error("spare result held with output register empty");

    a_restart_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_next) |=> (row_pos_reg == row_last_reg && col_pos_reg == col_last_reg))
        else $error("position not restarted after final cell");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (row_pos_reg <= row_last_reg) && (col_pos_reg <= col_last_reg))
        else $error("cell position beyond grid shape");

endmodule
